>>> hw/rtl/pbc_pkg.sv
// types and constants shared by the particle boundary classifier
package pbc_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned DIR_W   = 4;
    localparam int unsigned IDX_W   = 16;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned MASK_W  = 8;
    localparam int unsigned NDIR    = 8;
    localparam int unsigned DSEL_W  = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_XLO      = 4'd0;
    localparam logic [DIR_W-1:0] DIR_XHI      = 4'd1;
    localparam logic [DIR_W-1:0] DIR_YLO      = 4'd2;
    localparam logic [DIR_W-1:0] DIR_YHI      = 4'd3;
    localparam logic [DIR_W-1:0] DIR_XLO_YLO  = 4'd4;
    localparam logic [DIR_W-1:0] DIR_XHI_YLO  = 4'd5;
    localparam logic [DIR_W-1:0] DIR_XLO_YHI  = 4'd6;
    localparam logic [DIR_W-1:0] DIR_XHI_YHI  = 4'd7;
    localparam logic [DIR_W-1:0] DIR_STAY     = 4'd8;

    localparam logic [DSEL_W-1:0] DSEL_LAST   = 3'd7;

    // result kinds
    localparam logic KIND_CLASS  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIST_MASK  = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      is_dead_flag;
        logic                      last_particle;
    } pbc_in_t;

    typedef struct packed {
        logic               kind;
        logic [DIR_W-1:0]   direction;
        logic [IDX_W-1:0]   particle_index;
        logic [IDX_W-1:0]   slot;
        logic               store;
        logic [COUNT_W-1:0] count;
        logic               last_of_run;
    } pbc_out_t;

    // classified request passed from front to back
    typedef struct packed {
        logic [DIR_W-1:0] direction;
        logic [IDX_W-1:0] particle_index;
        logic             last;
    } pbc_cmd_t;

endpackage

>>> hw/rtl/pbc_front.sv
// front end: configuration registers, particle position counter and box classification
module pbc_front
    import pbc_pkg::*;
#(
    parameter int unsigned MAX_PARTICLES = 65536
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  particle_valid,
    input  pbc_in_t               particle,
    input  logic                  queue_full,
    output logic                  push,
    output pbc_cmd_t              cmd,
    output logic [MASK_W-1:0]     list_enable_mask
);

    localparam int unsigned PCNT_W = $clog2(MAX_PARTICLES);
    localparam logic [PCNT_W:0] PCNT_LIMIT = (PCNT_W + 1)'(MAX_PARTICLES);

    logic signed [COORD_W-1:0] box_x_low_reg;
    logic signed [COORD_W-1:0] box_x_high_reg;
    logic signed [COORD_W-1:0] box_y_low_reg;
    logic signed [COORD_W-1:0] box_y_high_reg;
    logic [MASK_W-1:0]         mask_reg;
    logic [PCNT_W-1:0]         pcnt_reg;
    logic [PCNT_W-1:0]         pcnt_next;
    logic [PCNT_W:0]           pcnt_inc;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      xl;
    logic                      xh;
    logic [DIR_W-1:0]          dir;

    assign px = particle.pos_x;
    assign py = particle.pos_y;
    assign xl = px < box_x_low_reg;
    assign xh = px > box_x_high_reg;

    always_comb
    begin
        if (particle.is_dead_flag)
            dir = DIR_STAY;
        else if (py < box_y_low_reg)
            dir = xl ? DIR_XLO_YLO : (xh ? DIR_XHI_YLO : DIR_YLO);
        else if (py > box_y_high_reg)
            dir = xl ? DIR_XLO_YHI : (xh ? DIR_XHI_YHI : DIR_YHI);
        else if (xl)
            dir = DIR_XLO;
        else if (xh)
            dir = DIR_XHI;
        else
            dir = DIR_STAY;
    end

    assign push = particle_valid && !queue_full;

    assign cmd.direction      = dir;
    assign cmd.particle_index = IDX_W'(pcnt_reg);
    assign cmd.last           = particle.last_particle;

    assign pcnt_inc = {1'b0, pcnt_reg} + (PCNT_W + 1)'(1);

    always_comb
    begin
        pcnt_next = pcnt_reg;
        if (push)
        begin
            if (particle.last_particle || pcnt_inc >= PCNT_LIMIT)
                pcnt_next = '0;
            else
                pcnt_next = pcnt_inc[PCNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pcnt_reg <= '0;
        else
            pcnt_reg <= pcnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_low_reg  <= '0;
            box_x_high_reg <= '0;
            box_y_low_reg  <= '0;
            box_y_high_reg <= '0;
            mask_reg       <= '1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BOX_X_LOW:  box_x_low_reg  <= cfg_data;
                REG_BOX_X_HIGH: box_x_high_reg <= cfg_data;
                REG_BOX_Y_LOW:  box_y_low_reg  <= cfg_data;
                REG_BOX_Y_HIGH: box_y_high_reg <= cfg_data;
                REG_LIST_MASK:  mask_reg       <= cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign list_enable_mask = mask_reg;

endmodule

>>> hw/rtl/pbc_queue.sv
// small fifo of classified requests between front and back
module pbc_queue
    import pbc_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pbc_cmd_t push_cmd,
    input  logic     pop,
    output pbc_cmd_t head,
    output logic     empty,
    output logic     full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pbc_cmd_t          entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign empty   = cnt_reg == '0;
    assign full    = cnt_reg == CNT_FULL;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

>>> hw/rtl/pbc_back.sv
// back end: direction counters, count reports and the result register
module pbc_back
    import pbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pbc_cmd_t          head,
    input  logic              empty,
    input  logic [MASK_W-1:0] list_enable_mask,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output pbc_out_t          result
);

    typedef enum logic {
        ST_CLASS,
        ST_REPORT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [DSEL_W-1:0]   rep_reg;
    logic [DSEL_W-1:0]   rep_next;
    logic [COUNT_W-1:0]  counts_reg [NDIR];
    logic [COUNT_W-1:0]  counts_next [NDIR];
    logic                valid_reg;
    logic                valid_next;
    pbc_out_t            result_reg;
    pbc_out_t            result_next;
    logic                load;
    logic [DSEL_W-1:0]   dsel;
    logic [COUNT_W-1:0]  cur_count;

    // result register may be refilled when empty or being taken
    assign load      = !valid_reg || !result_stall;
    assign dsel      = head.direction[DSEL_W-1:0];
    assign cur_count = counts_reg[(state_reg == ST_REPORT) ? rep_reg : dsel];

    always_comb
    begin
        state_next  = state_reg;
        rep_next    = rep_reg;
        counts_next = counts_reg;
        valid_next  = valid_reg;
        result_next = result_reg;
        pop         = 1'b0;
        if (load)
        begin
            valid_next = 1'b0;
            unique case (state_reg)
                ST_REPORT:
                begin
                    valid_next                 = 1'b1;
                    result_next                = '0;
                    result_next.kind           = KIND_REPORT;
                    result_next.direction      = {1'b0, rep_reg};
                    result_next.count          = cur_count;
                    result_next.last_of_run    = rep_reg == DSEL_LAST;
                    counts_next[rep_reg]       = '0;
                    rep_next                   = rep_reg + DSEL_W'(1);
                    if (rep_reg == DSEL_LAST)
                        state_next = ST_CLASS;
                end
                ST_CLASS:
                begin
                    if (!empty)
                    begin
                        pop                        = 1'b1;
                        valid_next                 = 1'b1;
                        result_next                = '0;
                        result_next.kind           = KIND_CLASS;
                        result_next.direction      = head.direction;
                        result_next.particle_index = head.particle_index;
                        result_next.last_of_run    = !head.last;
                        // stay or dead leaves the counters alone
                        if (head.direction != DIR_STAY)
                        begin
                            result_next.slot  = cur_count[IDX_W-1:0];
                            result_next.store = list_enable_mask[dsel];
                            if (cur_count != COUNT_MAX)
                                counts_next[dsel] = cur_count + COUNT_W'(1);
                        end
                        if (head.last)
                        begin
                            state_next = ST_REPORT;
                            rep_next   = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLASS;
            rep_reg    <= '0;
            valid_reg  <= 1'b0;
            for (int i = 0; i < NDIR; i++)
                counts_reg[i] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rep_reg    <= rep_next;
            valid_reg  <= valid_next;
            counts_reg <= counts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

>>> hw/rtl/particle_boundary_classifier.sv
// top level of the particle boundary classifier
//
// particles enter on particle/particle_valid/particle_stall; a request is taken at a
// clock edge with particle_valid high and particle_stall low. each live particle is
// binned against the box (strict signed compares, y first) into one of eight
// neighbour directions or "stays", and gets a slot from that direction's counter.
// results leave on result/result_valid/result_stall under the same rule.
// a taken request is queued, then popped into the result register. throughput: one
// particle per cycle while particle_stall is low; a particle with last_particle set
// occupies the back end for its classification plus eight count reports that clear
// the counters; the particle position returns to zero when that particle is taken.
// a request queue of QUEUE_DEPTH entries sits between the classifying front end and
// the counting back end; particle_stall rises only when that queue is full, so a
// stalled receiver holds the result register and backs up through the queue.
// registers are written via cfg_write/cfg_index/cfg_data; the user must do so while
// the block is idle, unenforced; reset zeroes box and counters, enables all lists.
module particle_boundary_classifier
    import pbc_pkg::*;
#(
    parameter int unsigned MAX_PARTICLES = 65536,
    parameter int unsigned QUEUE_DEPTH   = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  particle_valid,
    output logic                  particle_stall,
    input  pbc_in_t               particle,
    output logic                  result_valid,
    input  logic                  result_stall,
    output pbc_out_t              result
);

    logic              push;
    logic              pop;
    logic              empty;
    logic              full;
    pbc_cmd_t          push_cmd;
    pbc_cmd_t          head;
    logic [MASK_W-1:0] list_enable_mask;

    assign particle_stall = full;

    pbc_front #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .particle_valid   (particle_valid),
        .particle         (particle),
        .queue_full       (full),
        .push             (push),
        .cmd              (push_cmd),
        .list_enable_mask (list_enable_mask)
    );

    pbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    pbc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .empty            (empty),
        .list_enable_mask (list_enable_mask),
        .pop              (pop),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .result           (result)
    );

endmodule
